// ----- src/ffts_pkg.sv -----
// Package for the first-fit time slot scheduler.
// Holds field widths, parameter defaults and the controller/datapath interface types.
// No dependencies.
`default_nettype none
package ffts_pkg;

   localparam int JOBS_DEFAULT = 32;
   localparam int MACHINES_DEFAULT = 32;
   localparam int GAPS_DEFAULT = 64;
   localparam int TIME_BITS_DEFAULT = 16;

   localparam int JOB_W = 5;
   localparam int MACH_W = 5;
   localparam int DUR_W = 12;
   localparam int OUT_TIME_W = 16;

   typedef struct packed {
      logic load;
      logic scan;
      logic decide;
      logic shift;
      logic fix_lo;
      logic fix_hi;
      logic commit;
      logic ovf;
   } cmd_type;

   typedef struct packed {
      logic scan_fit;
      logic scan_miss;
      logic dur_zero;
      logic split_two;
      logic split_none;
      logic list_full;
      logic shift_done;
   } status_type;

endpackage
`default_nettype wire

// ----- src/ffts_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module ffts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ----- src/ffts_ctrl.sv -----
// Controller state machine of the first-fit time slot scheduler.
// Depends on ffts_pkg for the command and status types.
`default_nettype none
module ffts_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   output ffts_pkg::cmd_type        cmd,
   input  wire ffts_pkg::status_type status
);
   import ffts_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_SHIFT  = 3'd3;
   localparam logic [2:0] ST_FIX1   = 3'd4;
   localparam logic [2:0] ST_FIX2   = 3'd5;
   localparam logic [2:0] ST_COMMIT = 3'd6;
   localparam logic [2:0] ST_OVF    = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_fit) begin
               state_in = ST_DECIDE;
            end else if (status.scan_miss) begin
               state_in = ST_OVF;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (status.dur_zero) begin
               state_in = ST_COMMIT;
            end else if (status.split_two && status.list_full) begin
               state_in = ST_OVF;
            end else if (status.split_two || status.split_none) begin
               state_in = ST_SHIFT;
            end else begin
               state_in = ST_FIX1;
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (status.shift_done) begin
               state_in = status.split_two ? ST_FIX1 : ST_COMMIT;
            end
         end
         ST_FIX1: begin
            cmd.fix_lo = 1'b1;
            state_in = status.split_two ? ST_FIX2 : ST_COMMIT;
         end
         ST_FIX2: begin
            cmd.fix_hi = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = ST_IDLE;
         end
         ST_OVF: begin
            cmd.ovf = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/ffts_dp.sv -----
// Datapath of the first-fit time slot scheduler: job and gap tables, gap scan,
// list shifting and result registers. Depends on ffts_pkg and ffts_ram.
`default_nettype none
module ffts_dp #(
   parameter int JOBS = ffts_pkg::JOBS_DEFAULT,
   parameter int MACHINES = ffts_pkg::MACHINES_DEFAULT,
   parameter int GAPS_PER_MACHINE = ffts_pkg::GAPS_DEFAULT,
   parameter int TIME_BITS = ffts_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ffts_pkg::cmd_type                   cmd,
   output ffts_pkg::status_type                     status,
   input  wire logic [ffts_pkg::JOB_W-1:0]          req_job_id,
   input  wire logic [ffts_pkg::MACH_W-1:0]         req_machine_id,
   input  wire logic [ffts_pkg::DUR_W-1:0]          req_duration,
   output logic                                     rsp_strobe,
   output logic      [ffts_pkg::OUT_TIME_W-1:0]     rsp_start_time,
   output logic      [ffts_pkg::OUT_TIME_W-1:0]     rsp_finish_time,
   output logic      [ffts_pkg::OUT_TIME_W-1:0]     rsp_makespan,
   output logic                                     rsp_overflow
);
   import ffts_pkg::*;

   localparam int G = GAPS_PER_MACHINE;
   localparam int TB = TIME_BITS;
   localparam int JIW = (JOBS > 1) ? $clog2(JOBS) : 1;
   localparam int MIW = (MACHINES > 1) ? $clog2(MACHINES) : 1;
   localparam int GIW = $clog2(G);
   localparam int CW = $clog2(G + 1);
   localparam int DEPTH = MACHINES * G;
   localparam int AW = $clog2(DEPTH);
   localparam int CMPW = TB + DUR_W + 1;
   localparam logic [TB-1:0] HORIZON = {TB{1'b1}};

   function automatic logic [7:0] mod_small(input logic [7:0] v, input logic [8:0] d);
      logic [12:0] rem;
      logic [12:0] sub;
      rem = 13'(v);
      for (int b = 4; b >= 0; b--) begin
         sub = 13'(d) << b;
         if (rem >= sub) begin
            rem = rem - sub;
         end
      end
      return rem[7:0];
   endfunction

   logic [TB-1:0]   job_ready_ff [JOBS];
   logic [CW-1:0]   gap_cnt_ff [MACHINES];
   logic [MACHINES-1:0] mvalid_ff;
   logic [TB-1:0]   makespan_ff, makespan_in;

   logic [JIW-1:0]  job_ff, job_in;
   logic [MIW-1:0]  mach_ff, mach_in;
   logic [DUR_W-1:0] dur_ff, dur_in;
   logic [TB-1:0]   ready_ff, ready_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            virt_ff, virt_in;

   logic [CW-1:0]   rd_idx_ff, rd_idx_in;
   logic            ev_vld_ff, ev_vld_in;
   logic [GIW-1:0]  ev_idx_ff, ev_idx_in;

   logic [GIW-1:0]  hit_ff, hit_in;
   logic [TB-1:0]   s_ff, s_in, l_ff, l_in, r_ff, r_in, fin_ff, fin_in;

   logic [CW-1:0]   mv_ff, mv_in;
   logic [CW-1:0]   sh_rd_ff, sh_rd_in;
   logic            wr_pend_ff, wr_pend_in;
   logic [CW-1:0]   wr_idx_ff, wr_idx_in;
   logic            up_ff, up_in;

   logic            rsp_strobe_in;
   logic [OUT_TIME_W-1:0] rsp_start_in, rsp_finish_in, rsp_makespan_in;
   logic            rsp_overflow_in;

   logic [JIW-1:0]  req_jidx;
   logic [MIW-1:0]  req_midx;
   logic [AW-1:0]   base;
   logic [GIW-1:0]  rd_sel;
   logic [AW-1:0]   ram_raddr, ram_waddr;
   logic            ram_wen;
   logic [2*TB-1:0] ram_wdata, ram_rdata, gap_data;
   logic [TB-1:0]   gl, gr, s_c, fin_c;
   logic [TB:0]     diff_c;
   logic            fit_c;
   logic            rd_more;
   logic            cut_left, cut_right;
   logic [CW-1:0]   cnt_new;

   assign req_jidx = JIW'(mod_small(8'(req_job_id), 9'(JOBS)));
   assign req_midx = MIW'(mod_small(8'(req_machine_id), 9'(MACHINES)));

   assign base = AW'(mach_ff) * AW'(G);
   assign rd_sel = cmd.shift ? sh_rd_ff[GIW-1:0] : rd_idx_ff[GIW-1:0];
   assign ram_raddr = base + AW'(rd_sel);

   assign gap_data = virt_ff ? {{TB{1'b0}}, HORIZON} : ram_rdata;
   assign gl = gap_data[2*TB-1:TB];
   assign gr = gap_data[TB-1:0];
   assign s_c = (gl > ready_ff) ? gl : ready_ff;
   assign diff_c = {1'b0, gr} - {1'b0, s_c};
   assign fit_c = ev_vld_ff && !diff_c[TB] && (CMPW'(diff_c[TB-1:0]) >= CMPW'(dur_ff));
   assign fin_c = TB'(CMPW'(s_c) + CMPW'(dur_ff));
   assign rd_more = (rd_idx_ff < cnt_ff);

   assign cut_left = (s_ff > l_ff);
   assign cut_right = (fin_ff < r_ff);

   assign status.scan_fit = fit_c;
   assign status.scan_miss = !ev_vld_ff && !rd_more;
   assign status.dur_zero = (dur_ff == '0);
   assign status.split_two = cut_left && cut_right;
   assign status.split_none = !cut_left && !cut_right;
   assign status.list_full = (cnt_ff >= CW'(G));
   assign status.shift_done = (mv_ff == '0) && !wr_pend_ff;

   always_comb begin
      ram_wen = 1'b0;
      ram_waddr = base + AW'(hit_ff);
      ram_wdata = cut_left ? {l_ff, s_ff} : {fin_ff, r_ff};
      if (cmd.shift && wr_pend_ff) begin
         ram_wen = 1'b1;
         ram_waddr = base + AW'(wr_idx_ff[GIW-1:0]);
         ram_wdata = gap_data;
      end else if (cmd.fix_lo) begin
         ram_wen = 1'b1;
      end else if (cmd.fix_hi) begin
         ram_wen = 1'b1;
         ram_waddr = base + AW'(GIW'(hit_ff + GIW'(1)));
         ram_wdata = {fin_ff, r_ff};
      end
   end

   ffts_ram #(
      .WIDTH(2 * TB),
      .DEPTH(DEPTH)
   ) u_gap_ram (
      .clock     (clock),
      .wr_en     (ram_wen),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_addr   (ram_raddr),
      .rd_data_ff(ram_rdata)
   );

   always_comb begin
      if (status.split_two) begin
         cnt_new = cnt_ff + CW'(1);
      end else if (status.split_none) begin
         cnt_new = cnt_ff - CW'(1);
      end else begin
         cnt_new = cnt_ff;
      end
   end

   always_comb begin
      job_in = job_ff;
      mach_in = mach_ff;
      dur_in = dur_ff;
      ready_in = ready_ff;
      cnt_in = cnt_ff;
      virt_in = virt_ff;
      rd_idx_in = rd_idx_ff;
      ev_vld_in = 1'b0;
      ev_idx_in = rd_idx_ff[GIW-1:0];
      hit_in = hit_ff;
      s_in = s_ff;
      l_in = l_ff;
      r_in = r_ff;
      fin_in = fin_ff;
      mv_in = mv_ff;
      sh_rd_in = sh_rd_ff;
      wr_pend_in = 1'b0;
      wr_idx_in = wr_idx_ff;
      up_in = up_ff;
      makespan_in = makespan_ff;
      rsp_strobe_in = cmd.commit || cmd.ovf;
      rsp_start_in = rsp_start_time;
      rsp_finish_in = rsp_finish_time;
      rsp_makespan_in = rsp_makespan;
      rsp_overflow_in = rsp_overflow;

      if (cmd.load) begin
         job_in = req_jidx;
         mach_in = req_midx;
         dur_in = req_duration;
         ready_in = job_ready_ff[req_jidx];
         cnt_in = gap_cnt_ff[req_midx];
         virt_in = !mvalid_ff[req_midx];
         rd_idx_in = '0;
      end

      if (cmd.scan) begin
         if (rd_more) begin
            rd_idx_in = rd_idx_ff + CW'(1);
            ev_vld_in = 1'b1;
         end
         if (fit_c) begin
            hit_in = ev_idx_ff;
            s_in = s_c;
            l_in = gl;
            r_in = gr;
            fin_in = fin_c;
         end
      end

      if (cmd.decide) begin
         mv_in = cnt_ff - CW'(1) - CW'(hit_ff);
         up_in = status.split_two;
         sh_rd_in = status.split_two ? (cnt_ff - CW'(1)) : (CW'(hit_ff) + CW'(1));
      end

      if (cmd.shift && (mv_ff != '0)) begin
         mv_in = mv_ff - CW'(1);
         sh_rd_in = up_ff ? (sh_rd_ff - CW'(1)) : (sh_rd_ff + CW'(1));
         wr_pend_in = 1'b1;
         wr_idx_in = up_ff ? (sh_rd_ff + CW'(1)) : (sh_rd_ff - CW'(1));
      end

      if (cmd.commit) begin
         if (fin_ff > makespan_ff) begin
            makespan_in = fin_ff;
         end
         rsp_start_in = OUT_TIME_W'(s_ff);
         rsp_finish_in = OUT_TIME_W'(fin_ff);
         rsp_makespan_in = OUT_TIME_W'((fin_ff > makespan_ff) ? fin_ff : makespan_ff);
         rsp_overflow_in = 1'b0;
      end

      if (cmd.ovf) begin
         rsp_start_in = '0;
         rsp_finish_in = '0;
         rsp_makespan_in = OUT_TIME_W'(makespan_ff);
         rsp_overflow_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < JOBS; j++) begin
            job_ready_ff[j] <= '0;
         end
         for (int m = 0; m < MACHINES; m++) begin
            gap_cnt_ff[m] <= CW'(1);
         end
         mvalid_ff <= '0;
         makespan_ff <= '0;
         ev_vld_ff <= 1'b0;
         wr_pend_ff <= 1'b0;
         rsp_strobe <= 1'b0;
      end else begin
         if (cmd.commit) begin
            job_ready_ff[job_ff] <= fin_ff;
            if (!status.dur_zero) begin
               gap_cnt_ff[mach_ff] <= cnt_new;
               mvalid_ff[mach_ff] <= 1'b1;
            end
         end
         makespan_ff <= makespan_in;
         ev_vld_ff <= ev_vld_in;
         wr_pend_ff <= wr_pend_in;
         rsp_strobe <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      mach_ff <= mach_in;
      dur_ff <= dur_in;
      ready_ff <= ready_in;
      cnt_ff <= cnt_in;
      virt_ff <= virt_in;
      rd_idx_ff <= rd_idx_in;
      ev_idx_ff <= ev_idx_in;
      hit_ff <= hit_in;
      s_ff <= s_in;
      l_ff <= l_in;
      r_ff <= r_in;
      fin_ff <= fin_in;
      mv_ff <= mv_in;
      sh_rd_ff <= sh_rd_in;
      wr_idx_ff <= wr_idx_in;
      up_ff <= up_in;
      rsp_start_time <= rsp_start_in;
      rsp_finish_time <= rsp_finish_in;
      rsp_makespan <= rsp_makespan_in;
      rsp_overflow <= rsp_overflow_in;
   end

endmodule
`default_nettype wire

// ----- src/first_fit_time_slot_scheduler.sv -----
// Top level of the first-fit time slot scheduler.
// Instantiates ffts_ctrl and ffts_dp; depends on ffts_pkg.
//
// A request is taken when start is high while busy is low; busy then stays high
// until the result has been registered. Each request yields exactly one result,
// shown for a single cycle with rsp_strobe high; the receiver cannot stall it and
// must capture it in that cycle. The time a request takes grows with the
// position of the chosen gap in the machine's list and with the number of gaps
// moved to open or close a slot. The gap memory has one read and one write
// port: the scan reads one gap per cycle and the list shift moves one gap per
// cycle. No clearing pass is needed after reset.
`default_nettype none
module first_fit_time_slot_scheduler #(
   parameter int JOBS = ffts_pkg::JOBS_DEFAULT,
   parameter int MACHINES = ffts_pkg::MACHINES_DEFAULT,
   parameter int GAPS_PER_MACHINE = ffts_pkg::GAPS_DEFAULT,
   parameter int TIME_BITS = ffts_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [ffts_pkg::JOB_W-1:0]      req_job_id,
   input  wire logic [ffts_pkg::MACH_W-1:0]     req_machine_id,
   input  wire logic [ffts_pkg::DUR_W-1:0]      req_duration,
   output logic                                 rsp_strobe,
   output logic      [ffts_pkg::OUT_TIME_W-1:0] rsp_start_time,
   output logic      [ffts_pkg::OUT_TIME_W-1:0] rsp_finish_time,
   output logic      [ffts_pkg::OUT_TIME_W-1:0] rsp_makespan,
   output logic                                 rsp_overflow
);
   import ffts_pkg::*;

   cmd_type    cmd;
   status_type status;

   ffts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .status(status)
   );

   ffts_dp #(
      .JOBS            (JOBS),
      .MACHINES        (MACHINES),
      .GAPS_PER_MACHINE(GAPS_PER_MACHINE),
      .TIME_BITS       (TIME_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_job_id     (req_job_id),
      .req_machine_id (req_machine_id),
      .req_duration   (req_duration),
      .rsp_strobe     (rsp_strobe),
      .rsp_start_time (rsp_start_time),
      .rsp_finish_time(rsp_finish_time),
      .rsp_makespan   (rsp_makespan),
      .rsp_overflow   (rsp_overflow)
   );

`ifndef ASSERT_OFF
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Accepted request did not raise busy.");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("Result shown while a request is still in work.");

   a_result_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Two results in consecutive cycles.");

   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_overflow) |-> (rsp_start_time == '0 && rsp_finish_time == '0))
      else $error("Overflow result carries nonzero times.");
`endif

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the first-fit time slot scheduler.
// Drives operation requests from a queue, predicts each placement and compares results.
// Depends on ffts_pkg and first_fit_time_slot_scheduler.
`default_nettype none
module tb_top;
   import ffts_pkg::*;

   localparam int NJOB = 32;
   localparam int NMACH = 32;
   localparam int NGAP = 64;
   localparam logic [15:0] HORIZON = 16'hFFFF;
   localparam int CYCLE_LIMIT = 1200000;

   typedef struct packed {
      logic [JOB_W-1:0]  job;
      logic [MACH_W-1:0] mach;
      logic [DUR_W-1:0]  dur;
      logic              hold;
   } op_type;

   typedef struct packed {
      logic [OUT_TIME_W-1:0] st;
      logic [OUT_TIME_W-1:0] fin;
      logic [OUT_TIME_W-1:0] mk;
      logic                  ovf;
   } place_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [JOB_W-1:0]  req_job_id = '0;
   logic [MACH_W-1:0] req_machine_id = '0;
   logic [DUR_W-1:0]  req_duration = '0;
   logic rsp_strobe;
   logic [OUT_TIME_W-1:0] rsp_start_time, rsp_finish_time, rsp_makespan;
   logic rsp_overflow;

   op_type    pending_ops[$];
   place_type expected_places[$];
   int        mismatches = 0;
   int        cycle_count = 0;
   int        gap_wait = 0;
   bit        stim_done = 1'b0;

   logic [15:0] ready_at[NJOB];
   logic [15:0] free_lo[NMACH][NGAP];
   logic [15:0] free_hi[NMACH][NGAP];
   int          free_cnt[NMACH];
   logic [15:0] span;

   first_fit_time_slot_scheduler i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_job_id(req_job_id), .req_machine_id(req_machine_id),
      .req_duration(req_duration), .rsp_strobe(rsp_strobe),
      .rsp_start_time(rsp_start_time), .rsp_finish_time(rsp_finish_time),
      .rsp_makespan(rsp_makespan), .rsp_overflow(rsp_overflow)
   );

   always #10 clock = ~clock;

   function automatic place_type place_operation(op_type op);
      place_type p;
      int m, j, i, cnt, pieces;
      logic [16:0] s, fin, l, r, d, rdy;
      bit found;
      m = int'(op.mach);
      j = int'(op.job);
      d = 17'(op.dur);
      rdy = 17'(ready_at[j]);
      cnt = free_cnt[m];
      found = 1'b0;
      s = '0;
      for (i = 0; i < cnt; i++) begin
         l = 17'(free_lo[m][i]);
         r = 17'(free_hi[m][i]);
         s = (l > rdy) ? l : rdy;
         if (s <= r && r - s >= d) begin
            found = 1'b1;
            break;
         end
      end
      p = '{st: '0, fin: '0, mk: span, ovf: 1'b1};
      if (!found) return p;
      l = 17'(free_lo[m][i]);
      r = 17'(free_hi[m][i]);
      fin = s + d;
      if (op.dur != '0) begin
         pieces = int'(s > l) + int'(fin < r);
         if (pieces == 2) begin
            if (cnt >= NGAP) return p;
            for (int k = cnt; k > i + 1; k--) begin
               free_lo[m][k] = free_lo[m][k-1];
               free_hi[m][k] = free_hi[m][k-1];
            end
            free_hi[m][i] = s[15:0];
            free_lo[m][i+1] = fin[15:0];
            free_hi[m][i+1] = r[15:0];
            cnt++;
         end else if (pieces == 1) begin
            if (s > l) free_hi[m][i] = s[15:0];
            else free_lo[m][i] = fin[15:0];
         end else begin
            for (int k = i; k + 1 < cnt; k++) begin
               free_lo[m][k] = free_lo[m][k+1];
               free_hi[m][k] = free_hi[m][k+1];
            end
            cnt--;
         end
         free_cnt[m] = cnt;
      end
      ready_at[j] = fin[15:0];
      if (fin[15:0] > span) span = fin[15:0];
      return '{st: s[15:0], fin: fin[15:0], mk: span, ovf: 1'b0};
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      mismatches++;
   endtask

   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
   endfunction

   // Driver: a request is accepted at a rising edge with start high and busy low.
   always @(negedge clock) begin
      if (!reset) begin
         if (!(start && busy)) begin
            if (gap_wait > 0) begin
               gap_wait <= gap_wait - 1;
               start <= 1'b0;
            end else if (pending_ops.size() > 0 &&
                         !(pending_ops[0].hold && expected_places.size() > 0)) begin
               op_type op;
               op = pending_ops.pop_front();
               expected_places.push_back(place_operation(op));
               req_job_id <= op.job;
               req_machine_id <= op.mach;
               req_duration <= op.dur;
               start <= 1'b1;
               gap_wait <= pick_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_strobe) begin
         if (expected_places.size() == 0) begin
            report_mismatch("unexpected result", rsp_start_time, 16'(0));
         end else begin
            place_type e;
            e = expected_places.pop_front();
            if (rsp_start_time !== e.st) report_mismatch("start", rsp_start_time, e.st);
            if (rsp_finish_time !== e.fin) report_mismatch("finish", rsp_finish_time, e.fin);
            if (rsp_makespan !== e.mk) report_mismatch("makespan", rsp_makespan, e.mk);
            if (rsp_overflow !== e.ovf) begin
               report_mismatch("overflow", 16'(rsp_overflow), 16'(e.ovf));
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic add_op(input int j, input int m, input int d, input bit h = 1'b0);
      op_type op;
      op.job = JOB_W'(j);
      op.mach = MACH_W'(m);
      op.dur = DUR_W'(d);
      op.hold = h;
      pending_ops.push_back(op);
   endtask

   initial begin
      int n, phase_ops;
      span = '0;
      for (int j = 0; j < NJOB; j++) ready_at[j] = '0;
      for (int m = 0; m < NMACH; m++) begin
         free_cnt[m] = 1;
         free_lo[m][0] = '0;
         free_hi[m][0] = HORIZON;
      end
      // Directed: extremes, zero-length pieces, gap reuse, no fit.
      add_op(0, 0, 1);
      add_op(31, 31, 4095);
      add_op(1, 0, 0);
      add_op(2, 0, 4095);
      add_op(0, 0, 10);
      add_op(3, 1, 100);
      add_op(3, 2, 50);
      add_op(4, 2, 50);
      add_op(4, 1, 1);
      add_op(5, 3, 4095);
      add_op(21, 21, 2730);
      add_op(10, 3, 0);
      for (int k = 0; k < 16; k++) add_op(6, 4, 4095);
      add_op(7, 4, 1, 1'b1);
      add_op(6, 4, 4095);
      // Random phases: fill machines, break the gap list, and run out of time.
      n = 0;
      while (n < 1150) begin
         phase_ops = $urandom_range(50, 200);
         for (int k = 0; k < phase_ops && n < 1150; k++, n++) begin
            int d;
            case ($urandom_range(0, 5))
               0: d = $urandom_range(0, 4095);
               1: d = $urandom_range(0, 3);
               2: d = 4095;
               default: d = $urandom_range(1, 300);
            endcase
            add_op($urandom_range(0, 31), $urandom_range(0, 7) == 0 ?
                   $urandom_range(0, 31) : $urandom_range(8, 11), d, k == 0);
         end
      end
      repeat (9) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      wait (pending_ops.size() == 0 && expected_places.size() == 0);
      repeat (2 * NGAP + 20) @(posedge clock);
      if (mismatches == 0 && expected_places.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- first_fit_time_slot_scheduler.f -----
src/ffts_pkg.sv
src/ffts_ram.sv
src/ffts_ctrl.sv
src/ffts_dp.sv
src/first_fit_time_slot_scheduler.sv
dv/tb_top.sv
